@@ src/aws_pkg.sv @@
// Shared types and constants for the adaptive-window encoder speed unit.
// Used by the channel interfaces, the divider and the top level.
// No dependencies.
package aws_pkg;

	// Default structural sizes.
	localparam int unsigned DEF_RING_DEPTH  = 64;
	localparam int unsigned DEF_WINDOW_STEP = 4;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_FREQ_HZ  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VAR_THRESHOLD  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_EVALS      = 4'd3;
	localparam logic [15:0] CPR_RESET       = 16'd400;
	localparam logic [31:0] FREQ_RESET      = 32'd100000000;
	localparam logic [23:0] THRESHOLD_RESET = 24'd1280;
	localparam logic [15:0] MIN_EVALS_RESET = 16'd10;

	// Item opcodes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Direction codes.
	localparam logic [1:0] DIR_STOPPED = 2'd0;
	localparam logic [1:0] DIR_FORWARD = 2'd1;
	localparam logic [1:0] DIR_REVERSE = 2'd2;

	// Speed saturation bounds.
	localparam logic signed [23:0] RPM_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] RPM_MIN = 24'sh800000;

	// Divider sizes: 80-bit dividend, 48-bit divisor, 32-bit quotient.
	localparam int unsigned DIV_NUM_W = 80;
	localparam int unsigned DIV_DEN_W = 48;
	localparam int unsigned DIV_Q_W   = 32;

	// Divider request and status.
	typedef struct packed {
		logic start;
		logic short_mode;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic big;
	} div_rsp_t;

endpackage

@@ src/aws_ifs.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on aws_pkg for the register port widths.
interface aws_sample_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] raw_position;
	logic [31:0] tick;
	modport source (output valid, op, raw_position, tick, input ready);
	modport sink (input valid, op, raw_position, tick, output ready);
endinterface

interface aws_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] rpm_q8;
	logic signed [31:0] position;
	logic signed [15:0] step_diff;
	logic [1:0]         direction;
	logic [6:0]         chosen_window;
	logic [31:0]        chosen_mean_variation_q8;
	logic               search_finished;
	modport source (output valid, rpm_q8, position, step_diff, direction, chosen_window,
		chosen_mean_variation_q8, search_finished, input ready);
	modport sink (input valid, rpm_q8, position, step_diff, direction, chosen_window,
		chosen_mean_variation_q8, search_finished, output ready);
endinterface

interface aws_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [aws_pkg::CFG_IDX_W-1:0]  index;
	logic [aws_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/encoder_adaptive_window_speed_unit.sv @@
// Adaptive-window speed estimator for a quadrature encoder. A start transaction
// (op 0) captures the raw count as baseline and clears position, ring and search
// state. A sample transaction unwraps the count step, updates position and
// direction, stores (tick, position) in the ring and, until the search has
// finished, evaluates every window length WINDOW_STEP..RING_DEPTH: each window
// takes a speed (ring read, three passes through one 32x32 multiplier and an
// 80-by-48-bit divide) and a mean-variation divide, and a final speed pass for
// the chosen window follows. Once the search has finished, a sample runs only
// that final speed pass. The shared divider retires one quotient bit per cycle.
// The block takes one transaction at a time; the result sits in an output
// register so the next transaction can enter while it waits. Register writes
// are always accepted. Depends on aws_pkg, aws_ifs, aws_div and aws_ring.
module encoder_adaptive_window_speed_unit #(
	parameter int unsigned RING_DEPTH  = aws_pkg::DEF_RING_DEPTH,
	parameter int unsigned WINDOW_STEP = aws_pkg::DEF_WINDOW_STEP
) (
	input logic         clk,
	input logic         arst_n,
	aws_sample_if.sink  samples,
	aws_result_if.source results,
	aws_cfg_if.sink     cfg
);
	import aws_pkg::*;

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned FW = $clog2(RING_DEPTH + 1);
	localparam int unsigned NW = RING_DEPTH / WINDOW_STEP;
	localparam int unsigned KW = (NW > 1) ? $clog2(NW) : 1;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_DIFF  = 4'd2;
	localparam logic [3:0] S_SCALE = 4'd3;
	localparam logic [3:0] S_MLO   = 4'd4;
	localparam logic [3:0] S_MHI   = 4'd5;
	localparam logic [3:0] S_MD    = 4'd6;
	localparam logic [3:0] S_DGO   = 4'd7;
	localparam logic [3:0] S_DW    = 4'd8;
	localparam logic [3:0] S_UPD   = 4'd9;
	localparam logic [3:0] S_MGO   = 4'd10;
	localparam logic [3:0] S_MW    = 4'd11;
	localparam logic [3:0] S_NEXT  = 4'd12;
	localparam logic [3:0] S_FSEL  = 4'd13;
	localparam logic [3:0] S_FIN   = 4'd14;

	// Configuration registers.
	logic [15:0] cpr_q;
	logic [31:0] freq_q;
	logic [23:0] thr_q;
	logic [15:0] min_evals_q;

	// Sequencer and sample state.
	logic [3:0]         state_q;
	logic               final_q;
	logic [KW-1:0]      k_q;
	logic [FW-1:0]      cur_w_q;
	logic [AW-1:0]      wi_q;
	logic [AW-1:0]      wr_slot_q;
	logic [FW-1:0]      fill_q;
	logic [15:0]        prev_raw_q;
	logic [31:0]        pos_q;
	logic [31:0]        tick_q;
	logic [15:0]        sd_q;
	logic [1:0]         dir_q;
	logic signed [23:0] last_rpm_q;

	// Per-window search state.
	logic signed [23:0] win_prev_q [NW];
	logic [31:0]        win_sum_q  [NW];
	logic [15:0]        win_cnt_q  [NW];
	logic               win_pv_q   [NW];
	logic [FW-1:0]      best_w_q;
	logic [31:0]        best_mean_q;
	logic               done_flag_q;
	logic               have_min_q;
	logic               found_q;
	logic [31:0]        min_mean_q;
	logic [FW-1:0]      min_w_q;

	// Speed datapath registers.
	logic [31:0]           dt_q;
	logic [31:0]           du_q;
	logic                  neg_q;
	logic [45:0]           a_q;
	logic [DIV_NUM_W-1:0]  num_q;
	logic [DIV_DEN_W-1:0]  den_q;
	logic signed [23:0]    rpm_q;

	// Output register.
	logic               out_valid_q;
	logic signed [23:0] o_rpm_q;
	logic [31:0]        o_pos_q;
	logic [15:0]        o_sd_q;
	logic [1:0]         o_dir_q;
	logic [6:0]         o_win_q;
	logic [31:0]        o_mean_q;
	logic               o_done_q;

	// Handshakes.
	logic accept;
	logic out_load;
	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;
	assign out_load      = (state_q == S_FIN) && (!out_valid_q || results.ready);

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q       <= CPR_RESET;
			freq_q      <= FREQ_RESET;
			thr_q       <= THRESHOLD_RESET;
			min_evals_q <= MIN_EVALS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_COUNTS_PER_REV: cpr_q       <= cfg.data[15:0];
				CFG_TIMER_FREQ_HZ:  freq_q      <= cfg.data;
				CFG_VAR_THRESHOLD:  thr_q       <= cfg.data[23:0];
				CFG_MIN_EVALS:      min_evals_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	// Count unwrap by half a revolution.
	logic signed [18:0] raw_diff;
	logic signed [18:0] half_s;
	logic signed [18:0] cpr_s;
	logic signed [18:0] step;
	logic [31:0]        pos_next;
	logic [15:0]        sd_next;
	logic [1:0]         dir_next;
	assign raw_diff = $signed({3'b0, samples.raw_position}) - $signed({3'b0, prev_raw_q});
	assign half_s   = $signed({4'b0, cpr_q[15:1]});
	assign cpr_s    = $signed({3'b0, cpr_q});
	always_comb begin
		if (raw_diff > half_s) begin
			step = raw_diff - cpr_s;
		end else if (raw_diff < -half_s) begin
			step = raw_diff + cpr_s;
		end else begin
			step = raw_diff;
		end
		pos_next = pos_q + 32'(step);
		if (step > 19'sd32767) begin
			sd_next = 16'h7FFF;
		end else if (step < -19'sd32768) begin
			sd_next = 16'h8000;
		end else begin
			sd_next = step[15:0];
		end
		if (step > 19'sd0) begin
			dir_next = DIR_FORWARD;
		end else if (step < 19'sd0) begin
			dir_next = DIR_REVERSE;
		end else begin
			dir_next = DIR_STOPPED;
		end
	end

	// Ring: write on each sample, read the oldest entry of the current window.
	logic        ring_we;
	logic [63:0] ring_rdata;
	logic [31:0] slot32;
	logic [31:0] wm1_32;
	logic [31:0] old32;
	assign ring_we = accept && (samples.op == OP_SAMPLE);
	assign slot32  = 32'(wr_slot_q);
	assign wm1_32  = 32'(cur_w_q) - 32'd1;
	assign old32   = (slot32 >= wm1_32) ? (slot32 - wm1_32) :
		(slot32 + RING_DEPTH - wm1_32);

	aws_ring #(
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wi_q),
		.wdata ({samples.tick, pos_next}),
		.raddr (old32[AW-1:0]),
		.rdata (ring_rdata)
	);

	// Shared 32x32 multiplier for the numerator halves and the denominator.
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	always_comb begin
		case (state_q)
			S_MLO: begin
				mul_a = a_q[31:0];
				mul_b = freq_q;
			end
			S_MHI: begin
				mul_a = {18'b0, a_q[45:32]};
				mul_b = freq_q;
			end
			default: begin
				mul_a = {16'b0, cpr_q};
				mul_b = dt_q;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// A window without enough evaluations gets no mean.
	logic mean_skip;
	assign mean_skip = (win_cnt_q[k_q] == 16'd0) || (win_cnt_q[k_q] < min_evals_q);

	// Shared divider: speed quotient and mean variation.
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic [DIV_Q_W-1:0]   div_quot;
	assign div_req.start      = (state_q == S_DGO) || (state_q == S_MGO && !mean_skip);
	assign div_req.short_mode = (state_q == S_MGO);
	assign div_num = (state_q == S_MGO) ? DIV_NUM_W'(win_sum_q[k_q]) : num_q;
	assign div_den = (state_q == S_MGO) ? DIV_DEN_W'(win_cnt_q[k_q]) : den_q;

	aws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_num),
		.divisor  (div_den),
		.rsp      (div_rsp),
		.quotient (div_quot)
	);

	// Signed, saturated speed from the quotient.
	logic               q_sat;
	logic signed [23:0] rpm_new;
	assign q_sat = div_rsp.big || (div_quot[31:23] != 9'd0);
	always_comb begin
		if (neg_q) begin
			rpm_new = q_sat ? RPM_MIN : -$signed({1'b0, div_quot[22:0]});
		end else begin
			rpm_new = q_sat ? RPM_MAX : $signed({1'b0, div_quot[22:0]});
		end
	end

	// Variation update for window k.
	logic signed [24:0] dv;
	logic [24:0]        dv_abs;
	logic [32:0]        sum_add;
	assign dv      = 25'(rpm_q) - 25'(win_prev_q[k_q]);
	assign dv_abs  = dv[24] ? 25'(-dv) : 25'(dv);
	assign sum_add = {1'b0, win_sum_q[k_q]} + 33'(dv_abs);

	// Magnitude of the position change.
	logic [31:0] mag;
	logic [35:0] mag15;
	assign mag   = du_q[31] ? (32'd0 - du_q) : du_q;
	assign mag15 = {mag, 4'b0} - 36'(mag);

	logic [FW-1:0] next_w;
	logic [FW-1:0] k_w;
	assign next_w = FW'((32'(k_q) + 32'd2) * WINDOW_STEP);
	assign k_w    = FW'((32'(k_q) + 32'd1) * WINDOW_STEP);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			final_q     <= 1'b0;
			k_q         <= '0;
			cur_w_q     <= '0;
			wi_q        <= '0;
			wr_slot_q   <= '0;
			fill_q      <= '0;
			prev_raw_q  <= '0;
			pos_q       <= '0;
			sd_q        <= '0;
			dir_q       <= DIR_STOPPED;
			last_rpm_q  <= '0;
			best_w_q    <= '0;
			best_mean_q <= '0;
			done_flag_q <= 1'b0;
			have_min_q  <= 1'b0;
			found_q     <= 1'b0;
			min_mean_q  <= '0;
			min_w_q     <= '0;
			for (int i = 0; i < NW; i++) begin
				win_prev_q[i] <= '0;
				win_sum_q[i]  <= '0;
				win_cnt_q[i]  <= '0;
				win_pv_q[i]   <= 1'b0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_raw_q <= samples.raw_position;
						if (samples.op == OP_START) begin
							pos_q       <= '0;
							sd_q        <= '0;
							dir_q       <= DIR_STOPPED;
							wi_q        <= '0;
							fill_q      <= '0;
							last_rpm_q  <= '0;
							best_w_q    <= '0;
							best_mean_q <= '0;
							done_flag_q <= 1'b0;
							for (int i = 0; i < NW; i++) begin
								win_prev_q[i] <= '0;
								win_sum_q[i]  <= '0;
								win_cnt_q[i]  <= '0;
								win_pv_q[i]   <= 1'b0;
							end
							state_q <= S_FIN;
						end else begin
							pos_q     <= pos_next;
							sd_q      <= sd_next;
							dir_q     <= dir_next;
							wr_slot_q <= wi_q;
							wi_q      <= (32'(wi_q) == RING_DEPTH - 1) ? '0 : wi_q + 1'b1;
							if (32'(fill_q) < RING_DEPTH) begin
								fill_q <= fill_q + 1'b1;
							end
							have_min_q <= 1'b0;
							found_q    <= 1'b0;
							k_q        <= '0;
							cur_w_q    <= FW'(WINDOW_STEP);
							final_q    <= 1'b0;
							state_q    <= done_flag_q ? S_FSEL : S_RD;
						end
					end
				end
				S_RD: begin
					if (fill_q < cur_w_q || cpr_q == 16'd0) begin
						state_q <= final_q ? S_FIN : S_MGO;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_SCALE;
				S_SCALE: begin
					if (dt_q == 32'd0) begin
						state_q <= final_q ? S_FIN : S_MGO;
					end else begin
						state_q <= S_MLO;
					end
				end
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_MD;
				S_MD:  state_q <= S_DGO;
				S_DGO: state_q <= S_DW;
				S_DW: begin
					if (div_rsp.done) begin
						if (final_q) begin
							last_rpm_q <= rpm_new;
							state_q    <= S_FIN;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (win_pv_q[k_q]) begin
						win_sum_q[k_q] <= sum_add[32] ? 32'hFFFFFFFF : sum_add[31:0];
						if (win_cnt_q[k_q] != 16'hFFFF) begin
							win_cnt_q[k_q] <= win_cnt_q[k_q] + 16'd1;
						end
					end
					win_prev_q[k_q] <= rpm_q;
					win_pv_q[k_q]   <= 1'b1;
					state_q         <= S_MGO;
				end
				S_MGO: state_q <= mean_skip ? S_NEXT : S_MW;
				S_MW: begin
					if (div_rsp.done) begin
						if (!have_min_q || div_quot < min_mean_q) begin
							have_min_q <= 1'b1;
							min_mean_q <= div_quot;
							min_w_q    <= k_w;
						end
						if (!found_q && div_quot <= 32'(thr_q)) begin
							best_w_q    <= k_w;
							best_mean_q <= div_quot;
							done_flag_q <= 1'b1;
							found_q     <= 1'b1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (32'(k_q) == NW - 1) begin
						if (!found_q && have_min_q) begin
							best_w_q    <= min_w_q;
							best_mean_q <= min_mean_q;
						end
						state_q <= S_FSEL;
					end else begin
						k_q     <= k_q + 1'b1;
						cur_w_q <= next_w;
						state_q <= S_RD;
					end
				end
				S_FSEL: begin
					if (best_w_q != '0) begin
						cur_w_q <= best_w_q;
						final_q <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Speed datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= samples.tick;
		end
		if (state_q == S_DIFF) begin
			dt_q <= tick_q - ring_rdata[63:32];
			du_q <= pos_q - ring_rdata[31:0];
		end
		if (state_q == S_SCALE) begin
			neg_q <= du_q[31];
			a_q   <= {mag15, 10'b0};
		end
		if (state_q == S_MLO) begin
			num_q <= DIV_NUM_W'(mul_p);
		end
		if (state_q == S_MHI) begin
			num_q <= num_q + {mul_p[DIV_NUM_W-33:0], 32'b0};
		end
		if (state_q == S_MD) begin
			den_q <= mul_p[DIV_DEN_W-1:0];
		end
		if (state_q == S_DW && div_rsp.done) begin
			rpm_q <= rpm_new;
		end
	end

	// Result register.
	logic [31:0] best_w32;
	assign best_w32 = 32'(best_w_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_rpm_q  <= last_rpm_q;
			o_pos_q  <= pos_q;
			o_sd_q   <= sd_q;
			o_dir_q  <= dir_q;
			o_win_q  <= best_w32[6:0];
			o_mean_q <= best_mean_q;
			o_done_q <= done_flag_q;
		end
	end

	assign results.valid                    = out_valid_q;
	assign results.rpm_q8                   = o_rpm_q;
	assign results.position                 = o_pos_q;
	assign results.step_diff                = o_sd_q;
	assign results.direction                = o_dir_q;
	assign results.chosen_window            = o_win_q;
	assign results.chosen_mean_variation_q8 = o_mean_q;
	assign results.search_finished          = o_done_q;

	// The divider is never restarted while it is still iterating.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// The ring fill level never passes the ring depth.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= RING_DEPTH)
		else $error("ring fill level out of range");

	// A finished search always names a window.
	a_done_win: assert property (@(posedge clk) disable iff (!arst_n)
		done_flag_q |-> best_w_q != '0)
		else $error("search finished without a chosen window");

	// A start transaction clears the position.
	a_start_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && samples.op == OP_START) |=> (pos_q == 32'd0 && fill_q == '0))
		else $error("start transaction did not clear state");

endmodule

@@ src/aws_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Long mode divides 80 by 48 bits, short mode 32 by 48 bits. Depends on aws_pkg.
module aws_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  aws_pkg::div_req_t               req,
	input  logic [aws_pkg::DIV_NUM_W-1:0]   dividend,
	input  logic [aws_pkg::DIV_DEN_W-1:0]   divisor,
	output aws_pkg::div_rsp_t               rsp,
	output logic [aws_pkg::DIV_Q_W-1:0]     quotient
);
	import aws_pkg::*;

	localparam logic [6:0] LONG_N  = 7'(DIV_NUM_W);
	localparam logic [6:0] SHORT_N = 7'(DIV_Q_W);

	logic [6:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 big_q;
	logic [DIV_NUM_W-1:0] dvd_q;
	logic [DIV_DEN_W-1:0] dsr_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   quot_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   trial_sub;
	logic                 fits;

	// Trial subtraction of the shifted partial remainder.
	assign trial     = {rem_q, dvd_q[DIV_NUM_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};

	// Iteration control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			big_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				big_q  <= 1'b0;
				cnt_q  <= req.short_mode ? SHORT_N : LONG_N;
			end else if (busy_q) begin
				big_q <= big_q | quot_q[DIV_Q_W-1];
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.short_mode ?
				{dividend[DIV_Q_W-1:0], {(DIV_NUM_W-DIV_Q_W){1'b0}}} : dividend;
			dsr_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quot_q <= {quot_q[DIV_Q_W-2:0], fits};
			dvd_q  <= {dvd_q[DIV_NUM_W-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.big  = big_q;
	assign quotient = quot_q;

endmodule

@@ src/aws_ring.sv @@
// Sample ring memory holding {tick, position} per entry.
// One write port and one registered read port. No package dependency.
module aws_ring #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [63:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [63:0]              rdata
);
	logic [63:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
